// ===== rtl/srwm_pkg.sv =====
package srwm_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int DIST_W    = 32;
  localparam int SCALE_W   = 32;
  localparam int SAMPLES_W = 5;
  localparam int LEN_W     = 5;
  localparam int MIND_W    = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE  = 4'd1;

  localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd15;
  localparam logic [MIND_W-1:0] MIND_RESET = 16'd1;

endpackage

// ===== rtl/srwm_ram.sv =====
module srwm_ram #(
  parameter int WIDTH = srwm_pkg::SCALE_W,
  parameter int DEPTH = srwm_pkg::WINDOW_MAX_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scale_ratio_window_median_unit.sv =====
// Channel | Direction | Ports                                      | Handshake
// in      | input     | in_odom_distance, in_visual_distance       | in_valid / in_ready
// out     | output    | out_scale, out_updated, out_samples_held   | out_valid / out_ready
// cfg     | input     | cfg_index, cfg_data                        | cfg_valid / cfg_ready
//
// An item that causes no update skips the divider and median search. An update
// runs the restoring divider, stores the ratio, then searches for the median
// over n held ratios: each candidate is loaded, then the window is swept with
// one RAM read per cycle, counting ratios below and equal to the candidate.
// Reset is synchronous, active low; held scale starts at 1.0, window empty.
// in_ready is high only while idle; a finished result waits in the output
// register without blocking the next item. cfg_ready is always high.
module scale_ratio_window_median_unit #(
  parameter int WINDOW_MAX = srwm_pkg::WINDOW_MAX_DEF,
  parameter int FRAC_BITS  = srwm_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [srwm_pkg::DIST_W-1:0]      in_odom_distance,
  input  logic [srwm_pkg::DIST_W-1:0]      in_visual_distance,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [srwm_pkg::SCALE_W-1:0]     out_scale,
  output logic                             out_updated,
  output logic [srwm_pkg::SAMPLES_W-1:0]   out_samples_held,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [srwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srwm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int DW = srwm_pkg::DIST_W + FRAC_BITS;
  localparam int SW = $clog2(DW + 1);
  localparam int RW = srwm_pkg::DIST_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_WRITE, S_CAND, S_CLOAD, S_SWEEP, S_TAIL, S_DONE
  } state_t;

  state_t state_r;

  logic [srwm_pkg::LEN_W-1:0]   len_r;
  logic [srwm_pkg::MIND_W-1:0]  mind_r;
  logic [CW-1:0]                count_r;
  logic [IW-1:0]                oldest_r;
  logic [srwm_pkg::SCALE_W-1:0] held_r;
  logic [RW-1:0]                vis_r;
  logic [RW-1:0]                rem_r;
  logic [DW-1:0]                dvd_r;
  logic [SW-1:0]                step_r;
  logic                         upd_r;
  logic [IW-1:0]                ci_r;
  logic [IW-1:0]                j_r;
  logic                         cmpv_r;
  logic [srwm_pkg::SCALE_W-1:0] cand_r;
  logic [CW-1:0]                less_r;
  logic [CW-1:0]                eq_r;
  logic                         out_valid_r;
  logic [srwm_pkg::SCALE_W-1:0] out_scale_r;
  logic                         out_updated_r;
  logic [srwm_pkg::SAMPLES_W-1:0] out_samples_r;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IW+1)'(WINDOW_MAX)) begin
      s = s - (IW+1)'(WINDOW_MAX);
    end
    return s[IW-1:0];
  endfunction

  logic                 go_upd;
  logic [RW:0]          trial;
  logic                 trial_ge;
  logic [RW:0]          trial_diff;
  logic [srwm_pkg::SCALE_W-1:0] ratio;
  logic [CW-1:0]        eff_len;
  logic                 full;
  logic [IW-1:0]        ins_slot;
  logic [CW-1:0]        cnt1;
  logic [IW-1:0]        old1;
  logic [CW-1:0]        surplus;
  logic [IW-1:0]        old2;
  logic [CW-1:0]        cnt2;
  logic                 ram_we;
  logic [IW-1:0]        ram_raddr;
  logic [srwm_pkg::SCALE_W-1:0] ram_rdata;
  logic [CW-1:0]        less_n;
  logic [CW-1:0]        eq_n;
  logic [CW-1:0]        med_k;
  logic                 found;
  logic                 out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_scale        = out_scale_r;
  assign out_updated      = out_updated_r;
  assign out_samples_held = out_samples_r;
  assign out_free = !out_valid_r || out_ready;

  assign go_upd = (in_odom_distance > RW'(mind_r)) && (in_visual_distance > RW'(mind_r));

  assign trial      = {rem_r, dvd_r[DW-1]};
  assign trial_ge   = trial >= {1'b0, vis_r};
  assign trial_diff = trial - {1'b0, vis_r};
  assign ratio      = (|dvd_r[DW-1:RW]) ? '1 : dvd_r[RW-1:0];

  always_comb begin
    if (len_r == '0) begin
      eff_len = CW'(1);
    end else if (32'(len_r) > WINDOW_MAX) begin
      eff_len = CW'(WINDOW_MAX);
    end else begin
      eff_len = CW'(len_r);
    end
  end

  always_comb begin
    full     = (count_r >= CW'(WINDOW_MAX));
    ins_slot = wrap_add(oldest_r, full ? '0 : count_r[IW-1:0]);
    cnt1     = full ? count_r : count_r + CW'(1);
    old1     = full ? wrap_add(oldest_r, IW'(1)) : oldest_r;
    surplus  = (cnt1 > eff_len) ? cnt1 - eff_len : '0;
    old2     = wrap_add(old1, surplus[IW-1:0]);
    cnt2     = cnt1 - surplus;
  end

  assign ram_we    = (state_r == S_WRITE);
  assign ram_raddr = wrap_add(oldest_r, (state_r == S_CAND) ? ci_r : j_r);

  srwm_ram #(
    .WIDTH (srwm_pkg::SCALE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ins_slot),
    .wdata (ratio),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    less_n = less_r;
    eq_n   = eq_r;
    if (cmpv_r) begin
      if (ram_rdata < cand_r) begin
        less_n = less_r + CW'(1);
      end
      if (ram_rdata == cand_r) begin
        eq_n = eq_r + CW'(1);
      end
    end
    med_k = count_r >> 1;
    found = (less_n <= med_k) && (med_k < less_n + eq_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= srwm_pkg::LEN_RESET;
      mind_r      <= srwm_pkg::MIND_RESET;
      count_r     <= '0;
      oldest_r    <= '0;
      held_r      <= srwm_pkg::SCALE_W'(1) << FRAC_BITS;
      out_valid_r <= 1'b0;
      cmpv_r      <= 1'b0;
      upd_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          srwm_pkg::CFG_WINDOW_LENGTH: len_r  <= cfg_data[srwm_pkg::LEN_W-1:0];
          srwm_pkg::CFG_MIN_DISTANCE:  mind_r <= cfg_data[srwm_pkg::MIND_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            vis_r  <= in_visual_distance;
            rem_r  <= '0;
            dvd_r  <= {in_odom_distance, FRAC_BITS'(0)};
            step_r <= '0;
            upd_r  <= go_upd;
            state_r <= go_upd ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          rem_r  <= trial_ge ? trial_diff[RW-1:0] : trial[RW-1:0];
          dvd_r  <= {dvd_r[DW-2:0], trial_ge};
          step_r <= step_r + SW'(1);
          if (step_r == SW'(DW - 1)) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          count_r  <= cnt2;
          oldest_r <= old2;
          ci_r     <= '0;
          state_r  <= S_CAND;
        end
        S_CAND: begin
          state_r <= S_CLOAD;
        end
        S_CLOAD: begin
          cand_r  <= ram_rdata;
          j_r     <= '0;
          less_r  <= '0;
          eq_r    <= '0;
          cmpv_r  <= 1'b0;
          state_r <= S_SWEEP;
        end
        S_SWEEP: begin
          less_r <= less_n;
          eq_r   <= eq_n;
          cmpv_r <= 1'b1;
          if (CW'(j_r) == count_r - CW'(1)) begin
            state_r <= S_TAIL;
          end else begin
            j_r <= j_r + IW'(1);
          end
        end
        S_TAIL: begin
          cmpv_r <= 1'b0;
          if (found) begin
            held_r  <= cand_r;
            state_r <= S_DONE;
          end else begin
            ci_r    <= ci_r + IW'(1);
            state_r <= S_CAND;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_scale_r   <= held_r;
            out_updated_r <= upd_r;
            out_samples_r <= srwm_pkg::SAMPLES_W'(count_r);
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WINDOW_MAX))
    else $error("window count above depth");

  a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(oldest_r) < WINDOW_MAX)
    else $error("oldest slot out of range");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < vis_r))
    else $error("divider remainder not below divisor");

  a_median_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CAND) |-> (count_r != '0 && count_r <= eff_len))
    else $error("median search over empty or oversized window");

  a_tail_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAIL) |-> (less_n + eq_n <= count_r))
    else $error("median counts exceed window");
`endif

endmodule
